>>> rtl/soc_pkg.sv
// Shared types and constants for the substring occurrence counter.
`timescale 1ns / 1ps

package soc_pkg;

   localparam int unsigned CMD_W = 2;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned COUNT_W = 16;

   localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TEXT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_PATTERN,
      OP_TEXT,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type op;
      logic [BYTE_W-1:0] byte_value;
      logic is_last;
   } item_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

>>> rtl/substring_occurrence_counter.sv
// Top level of the overlapping substring occurrence counter.
// The request channel carries one byte per transaction with a command:
// pattern byte, text byte or clear pattern. Pattern bytes build the pattern,
// and is_last closes it; each pattern byte or clear also restarts the text.
// Each text byte produces one response transaction with the match flag, the
// saturating running count, the end-of-text flag and the overflow flag.
// Pattern bytes, clears and unused commands produce no response.
// A request is first written into the queue when it is accepted. The response
// register is written from the match engine once the request reaches the queue
// head and the response register is free; the match engine compares the whole
// text window with the pattern in parallel.
// Throughput is one transaction per cycle on both channels without rsp_stall.
// When the receiver raises rsp_stall the response register holds its value,
// the two-entry queue fills, and req_stall rises once the queue is full.
// Reset empties the queue and the response register and clears the pattern
// length, pattern flags, window fill and count.
`timescale 1ns / 1ps

module substring_occurrence_counter #(
   parameter int unsigned PATTERN_MAX = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [soc_pkg::CMD_W-1:0]    req_cmd,
   input  logic [soc_pkg::BYTE_W-1:0]   req_byte_value,
   input  logic                         req_is_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_match_here,
   output logic [soc_pkg::COUNT_W-1:0]  rsp_match_total,
   output logic                         rsp_text_done,
   output logic                         rsp_pattern_error
);
   import soc_pkg::*;

   queue_status_type queue_status;
   item_type push_item;
   item_type head_item;
   logic push;
   logic pop;

   soc_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_byte_value (req_byte_value),
      .req_is_last    (req_is_last),
      .queue_status   (queue_status),
      .push           (push),
      .push_item      (push_item)
   );

   soc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (queue_status)
   );

   soc_back #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_status      (queue_status),
      .head_item         (head_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_match_here    (rsp_match_here),
      .rsp_match_total   (rsp_match_total),
      .rsp_text_done     (rsp_text_done),
      .rsp_pattern_error (rsp_pattern_error)
   );

endmodule

>>> rtl/soc_front.sv
// Front end: accepts request transactions, decodes the command and feeds the queue.
`timescale 1ns / 1ps

module soc_front (
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [soc_pkg::CMD_W-1:0]   req_cmd,
   input  logic [soc_pkg::BYTE_W-1:0]  req_byte_value,
   input  logic                        req_is_last,
   input  soc_pkg::queue_status_type   queue_status,
   output logic                        push,
   output soc_pkg::item_type           push_item
);
   import soc_pkg::*;

   logic known;
   op_type op;

   always_comb begin
      known = 1'b1;
      op = OP_TEXT;
      unique case (req_cmd)
         CMD_PATTERN: begin
            op = OP_PATTERN;
         end
         CMD_TEXT: begin
            op = OP_TEXT;
         end
         CMD_CLEAR: begin
            op = OP_CLEAR;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   // Unused commands are accepted and dropped without entering the queue.
   assign req_stall = queue_status.full;
   assign push = req_valid && !queue_status.full && known;
   assign push_item = '{op: op, byte_value: req_byte_value, is_last: req_is_last};

endmodule

>>> rtl/soc_queue.sv
// Short queue between the front end and the match engine.
`timescale 1ns / 1ps

module soc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  soc_pkg::item_type         push_item,
   input  logic                      pop,
   output soc_pkg::item_type         head_item,
   output soc_pkg::queue_status_type status
);
   import soc_pkg::*;

   item_type entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = entry_ff[rd_ptr_ff];
   assign status.full = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.valid = (count_ff != '0);

endmodule

>>> rtl/soc_back.sv
// Match engine: pattern and text window registers, parallel compare and result register.
`timescale 1ns / 1ps

module soc_back #(
   parameter int unsigned PATTERN_MAX = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  soc_pkg::queue_status_type    queue_status,
   input  soc_pkg::item_type            head_item,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_match_here,
   output logic [soc_pkg::COUNT_W-1:0]  rsp_match_total,
   output logic                         rsp_text_done,
   output logic                         rsp_pattern_error
);
   import soc_pkg::*;

   localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

   logic [BYTE_W-1:0] pat_ff [PATTERN_MAX];
   logic [BYTE_W-1:0] win_ff [PATTERN_MAX];
   logic [LEN_W-1:0] pat_len_ff, pat_len_in;
   logic pat_open_ff, pat_open_in;
   logic pat_ovf_ff, pat_ovf_in;
   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic match_ff, match_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic done_ff, done_in;
   logic error_ff, error_in;

   logic [PATTERN_MAX-1:0] agree;
   logic out_free;
   logic take_pattern;
   logic take_text;
   logic take_clear;
   logic pat_shift;
   logic [LEN_W-1:0] fill_next;
   logic hit;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop = queue_status.valid && ((head_item.op != OP_TEXT) || out_free);
   assign take_pattern = pop && (head_item.op == OP_PATTERN);
   assign take_text = pop && (head_item.op == OP_TEXT);
   assign take_clear = pop && (head_item.op == OP_CLEAR);

   assign fill_next = (fill_ff < LEN_W'(PATTERN_MAX)) ? fill_ff + 1'b1 : fill_ff;

   // The pattern register holds the newest pattern byte at position zero, so that
   // position k lines up with the text byte k places back from the newest one.
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cmp
      if (k == 0) begin : g_head
         assign agree[k] = (LEN_W'(k) >= pat_len_ff) || (head_item.byte_value == pat_ff[k]);
      end else begin : g_tail
         assign agree[k] = (LEN_W'(k) >= pat_len_ff) || (win_ff[k-1] == pat_ff[k]);
      end
   end

   assign hit = (pat_len_ff != '0) && !pat_open_ff && !pat_ovf_ff
      && (fill_next >= pat_len_ff) && (&agree);

   always_comb begin
      pat_len_in = pat_len_ff;
      pat_open_in = pat_open_ff;
      pat_ovf_in = pat_ovf_ff;
      fill_in = fill_ff;
      count_in = count_ff;
      pat_shift = 1'b0;
      match_in = match_ff;
      total_in = total_ff;
      done_in = done_ff;
      error_in = error_ff;
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (take_pattern) begin
         if (!pat_open_ff) begin
            pat_len_in = '0;
            pat_ovf_in = 1'b0;
         end
         if (pat_len_in < LEN_W'(PATTERN_MAX)) begin
            pat_shift = 1'b1;
            pat_len_in = pat_len_in + 1'b1;
         end else begin
            pat_ovf_in = 1'b1;
         end
         pat_open_in = !head_item.is_last;
         fill_in = '0;
         count_in = '0;
      end
      if (take_clear) begin
         pat_len_in = '0;
         pat_open_in = 1'b0;
         pat_ovf_in = 1'b0;
         fill_in = '0;
         count_in = '0;
      end
      if (take_text) begin
         count_in = (hit && (count_ff != COUNT_MAX)) ? count_ff + 1'b1 : count_ff;
         match_in = hit;
         total_in = count_in;
         done_in = head_item.is_last;
         error_in = pat_ovf_ff;
         rsp_valid_in = 1'b1;
         fill_in = fill_next;
         if (head_item.is_last) begin
            fill_in = '0;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff <= '0;
         pat_open_ff <= 1'b0;
         pat_ovf_ff <= 1'b0;
         fill_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pat_len_ff <= pat_len_in;
         pat_open_ff <= pat_open_in;
         pat_ovf_ff <= pat_ovf_in;
         fill_ff <= fill_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
      total_ff <= total_in;
      done_ff <= done_in;
      error_ff <= error_in;
   end

   always_ff @(posedge clock) begin
      if (pat_shift) begin
         pat_ff[0] <= head_item.byte_value;
         for (int unsigned i = 1; i < PATTERN_MAX; i++) begin
            pat_ff[i] <= pat_ff[i-1];
         end
      end
      if (take_text) begin
         win_ff[0] <= head_item.byte_value;
         for (int unsigned i = 1; i < PATTERN_MAX; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_match_here = match_ff;
   assign rsp_match_total = total_ff;
   assign rsp_text_done = done_ff;
   assign rsp_pattern_error = error_ff;

endmodule
